### rtl/core/morse_encoder_macros.svh
// assertion macros for the morse encoder checks
`ifndef MORSE_ENCODER_MACROS_SVH
`define MORSE_ENCODER_MACROS_SVH

// same-cycle implication, off while reset is applied
`define MRS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("morse encoder check failed");

// next-cycle implication, off while reset is applied
`define MRS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("morse encoder check failed");

`endif

### rtl/core/mrs_pkg.sv
package mrs_pkg;

	typedef enum logic [2:0] {
		SYM_DOT     = 3'd0,
		SYM_DASH    = 3'd1,
		SYM_GAP     = 3'd2,
		SYM_SLASH   = 3'd3,
		SYM_UNKNOWN = 3'd4
	} symbol_t;

	typedef enum logic [1:0] {
		RUN_SLASH,
		RUN_UNKNOWN,
		RUN_CODE
	} run_kind_t;

	typedef struct packed {
		logic      gap;
		run_kind_t kind;
	} run_ctl_t;

	localparam logic [7:0] CHAR_SPACE = 8'h20;
	// code bits kept in the 6-bit shift field
	localparam logic [7:0] CODE_MASK  = 8'h3F;

	// code behind a leading 1 marker, dot 0 dash 1, zero means no code
	function automatic logic [7:0] code_of(input logic [7:0] ch);
		logic [7:0] c;
		case (ch)
			8'h41: c = 8'd5;
			8'h42: c = 8'd24;
			8'h43: c = 8'd26;
			8'h44: c = 8'd12;
			8'h45: c = 8'd2;
			8'h46: c = 8'd18;
			8'h47: c = 8'd14;
			8'h48: c = 8'd16;
			8'h49: c = 8'd4;
			8'h4A: c = 8'd23;
			8'h4B: c = 8'd13;
			8'h4C: c = 8'd20;
			8'h4D: c = 8'd7;
			8'h4E: c = 8'd6;
			8'h4F: c = 8'd15;
			8'h50: c = 8'd22;
			8'h51: c = 8'd29;
			8'h52: c = 8'd10;
			8'h53: c = 8'd8;
			8'h54: c = 8'd3;
			8'h55: c = 8'd9;
			8'h56: c = 8'd17;
			8'h57: c = 8'd11;
			8'h58: c = 8'd25;
			8'h59: c = 8'd27;
			8'h5A: c = 8'd28;
			8'h30: c = 8'd63;
			8'h31: c = 8'd47;
			8'h32: c = 8'd39;
			8'h33: c = 8'd35;
			8'h34: c = 8'd33;
			8'h35: c = 8'd32;
			8'h36: c = 8'd48;
			8'h37: c = 8'd56;
			8'h38: c = 8'd60;
			8'h39: c = 8'd62;
			8'h2E: c = 8'd85;
			8'h2C: c = 8'd115;
			8'h3F: c = 8'd76;
			8'h27: c = 8'd94;
			8'h21: c = 8'd107;
			8'h2F: c = 8'd50;
			8'h28: c = 8'd54;
			8'h29: c = 8'd109;
			8'h26: c = 8'd40;
			8'h3A: c = 8'd120;
			8'h3B: c = 8'd106;
			8'h3D: c = 8'd49;
			8'h2B: c = 8'd42;
			8'h2D: c = 8'd97;
			8'h5F: c = 8'd77;
			8'h22: c = 8'd82;
			default: c = 8'd0;
		endcase
		return c;
	endfunction

endpackage

### rtl/core/mrs_char_if.sv
interface mrs_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;
	logic       new_message;

	modport source (output valid, output char_code, output new_message, input ready);
	modport sink (input valid, input char_code, input new_message, output ready);
endinterface

### rtl/core/mrs_sym_if.sv
interface mrs_sym_if;
	logic       valid;
	logic       ready;
	logic [2:0] symbol;
	logic       last;

	modport source (output valid, output symbol, output last, input ready);
	modport sink (input valid, input symbol, input last, output ready);
endinterface

### rtl/core/mrs_decode.sv
module mrs_decode
	import mrs_pkg::*;
#(
	parameter int MAX_CODE_LEN = 6
) (
	input  logic [7:0]                         char_code,
	input  logic                               new_message,
	input  logic                               started,
	output run_ctl_t                           ctl,
	output logic [$clog2(MAX_CODE_LEN+1)-1:0] len,
	output logic [MAX_CODE_LEN-1:0]            code
);

	localparam int LEN_W = $clog2(MAX_CODE_LEN + 1);

	logic [7:0]       packed_code;
	logic [2:0]       msb_pos;
	logic [7:0]       code_lo;
	logic [7:0]       aligned;

	assign packed_code = code_of(char_code);

	// position of the marker bit gives the length
	always_comb begin
		msb_pos = 3'd0;
		for (int i = 1; i < 8; i++) begin
			if (packed_code[i]) begin
				msb_pos = 3'(i);
			end
		end
	end

	always_comb begin
		if (LEN_W'(msb_pos) > LEN_W'(MAX_CODE_LEN)) begin
			len = LEN_W'(MAX_CODE_LEN);
		end else begin
			len = LEN_W'(msb_pos);
		end
	end

	// left-align so the first symbol sits in the top bit
	assign code_lo = packed_code & ((8'd1 << len) - 8'd1) & CODE_MASK;
	assign aligned = code_lo << (LEN_W'(MAX_CODE_LEN) - len);
	assign code    = aligned[MAX_CODE_LEN-1:0];

	always_comb begin
		ctl.gap = started && !new_message;
		if (char_code == CHAR_SPACE) begin
			ctl.kind = RUN_SLASH;
		end else if (packed_code[7:1] == 7'd0) begin
			ctl.kind = RUN_UNKNOWN;
		end else begin
			ctl.kind = RUN_CODE;
		end
	end

endmodule

### rtl/core/mrs_serializer.sv
module mrs_serializer
	import mrs_pkg::*;
#(
	parameter int MAX_CODE_LEN = 6
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               load,
	input  run_ctl_t                           ctl,
	input  logic [$clog2(MAX_CODE_LEN+1)-1:0] len,
	input  logic [MAX_CODE_LEN-1:0]            code,
	output logic                               can_load,
	mrs_sym_if.source                          syms
);

	localparam int LEN_W = $clog2(MAX_CODE_LEN + 1);

	logic                    busy_q;
	logic                    gap_q;
	run_kind_t               kind_q;
	logic [LEN_W-1:0]        cnt_q;
	logic [MAX_CODE_LEN-1:0] shift_q;
	logic                    valid_q;
	symbol_t                 sym_q;
	logic                    last_q;

	logic    out_free;
	logic    emit;
	logic    done;
	symbol_t sym_d;
	logic    last_d;

	assign out_free = !valid_q || syms.ready;
	assign emit     = busy_q && out_free;

	always_comb begin
		if (gap_q) begin
			sym_d  = SYM_GAP;
			last_d = 1'b0;
		end else begin
			case (kind_q)
				RUN_SLASH: begin
					sym_d  = SYM_SLASH;
					last_d = 1'b1;
				end
				RUN_CODE: begin
					sym_d  = shift_q[MAX_CODE_LEN-1] ? SYM_DASH : SYM_DOT;
					last_d = (cnt_q == LEN_W'(1));
				end
				default: begin
					sym_d  = SYM_UNKNOWN;
					last_d = 1'b1;
				end
			endcase
		end
	end

	assign done     = emit && last_d;
	// next word may enter as the last symbol of this one moves out
	assign can_load = !busy_q || done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			gap_q   <= 1'b0;
			kind_q  <= RUN_UNKNOWN;
			cnt_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			if (load) begin
				busy_q <= 1'b1;
				gap_q  <= ctl.gap;
				kind_q <= ctl.kind;
				cnt_q  <= len;
			end else if (emit) begin
				if (done) begin
					busy_q <= 1'b0;
				end
				if (gap_q) begin
					gap_q <= 1'b0;
				end else if (kind_q == RUN_CODE) begin
					cnt_q <= cnt_q - LEN_W'(1);
				end
			end
			if (emit) begin
				valid_q <= 1'b1;
			end else if (syms.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			shift_q <= code;
		end else if (emit && !gap_q && kind_q == RUN_CODE) begin
			shift_q <= shift_q << 1;
		end
		if (emit) begin
			sym_q  <= sym_d;
			last_q <= last_d;
		end
	end

	assign syms.valid  = valid_q;
	assign syms.symbol = sym_q;
	assign syms.last   = last_q;

endmodule

### rtl/core/morse_encoder.sv
// International Morse encoder: each word on chars is one 8-bit character and
// comes out on syms as a run of symbols (dot, dash, character gap, word slash
// or unknown marker), one symbol per word, the final one flagged by last. A
// character gap leads the run unless new_message is set or nothing has been
// sent since reset. Space gives a word slash; any byte without a code,
// lower case included, gives one unknown marker. A run holds 1 to 7 symbols
// (leading gap plus up to six dots and dashes), sent through the single output
// register that takes one symbol a cycle while syms is ready; the next character
// is taken in the cycle its predecessor's last symbol enters that register, so
// one-symbol runs flow at one character per cycle. Output stalls hold the run in
// place.
module morse_encoder
	import mrs_pkg::*;
#(
	parameter int MAX_CODE_LEN = 6
) (
	input  logic      clk,
	input  logic      arst_n,
	mrs_char_if.sink  chars,
	mrs_sym_if.source syms
);

	localparam int LEN_W = $clog2(MAX_CODE_LEN + 1);

	logic                    started_q;
	logic                    accept;
	logic                    can_load;
	run_ctl_t                ctl;
	logic [LEN_W-1:0]        len;
	logic [MAX_CODE_LEN-1:0] code;

	assign chars.ready = can_load;
	assign accept      = chars.valid && can_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q <= 1'b0;
		end else if (accept) begin
			started_q <= 1'b1;
		end
	end

	mrs_decode #(
		.MAX_CODE_LEN(MAX_CODE_LEN)
	) u_decode (
		.char_code  (chars.char_code),
		.new_message(chars.new_message),
		.started    (started_q),
		.ctl        (ctl),
		.len        (len),
		.code       (code)
	);

	mrs_serializer #(
		.MAX_CODE_LEN(MAX_CODE_LEN)
	) u_serializer (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (accept),
		.ctl     (ctl),
		.len     (len),
		.code    (code),
		.can_load(can_load),
		.syms    (syms)
	);

endmodule

### rtl/core/mrs_checker.sv
`include "morse_encoder_macros.svh"

module mrs_checker
	import mrs_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [2:0] out_symbol,
	input logic       out_last
);

	// a stalled word keeps its symbol and flag
	`MRS_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_symbol) && $stable(out_last))

	// only the five symbol codes appear
	`MRS_ASSERT_NOW(a_sym_range, clk, arst_n, out_valid, out_symbol <= SYM_UNKNOWN)

	// a gap always has more of its run behind it
	`MRS_ASSERT_NOW(a_gap_not_last, clk, arst_n, out_valid && out_symbol == SYM_GAP, !out_last)

	// slash and unknown marker end their run on their own
	`MRS_ASSERT_NOW(a_single_last, clk, arst_n, out_valid && (out_symbol == SYM_SLASH || out_symbol == SYM_UNKNOWN), out_last)

	// nothing is shown right after reset lets go
	`MRS_ASSERT_NOW(a_reset_empty, clk, arst_n, $rose(arst_n), !out_valid)

endmodule

bind morse_encoder mrs_checker u_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (syms.valid),
	.out_ready (syms.ready),
	.out_symbol(syms.symbol),
	.out_last  (syms.last)
);

### verif/tb.sv
module tb;
	import mrs_pkg::*;

	localparam int IDLE_LIMIT = 2000;
	localparam int RANDOM_CHARS = 440;

	typedef struct {
		symbol_t sym;
		logic    last;
	} sym_word_t;

	class morse_scoreboard;
		string      morse[bit [7:0]];
		bit [7:0]   coded_chars[$];
		sym_word_t  pending[$];
		bit         started;
		int         errors;
		int         chars_seen;
		int         spaces_seen;
		int         uncoded_seen;
		int         gaps_seen;
		int         syms_checked;

		function new();
			string entries[] = '{
				"A.-", "B-...", "C-.-.", "D-..", "E.", "F..-.", "G--.", "H....",
				"I..", "J.---", "K-.-", "L.-..", "M--", "N-.", "O---", "P.--.",
				"Q--.-", "R.-.", "S...", "T-", "U..-", "V...-", "W.--", "X-..-",
				"Y-.--", "Z--..",
				"0-----", "1.----", "2..---", "3...--", "4....-", "5.....",
				"6-....", "7--...", "8---..", "9----.",
				"..-.-.-", ",--..--", "?..--..", "'.----.", "!-.-.--", "/-..-.",
				"(-.--.", ")-.--.-", "&.-...", ":---...", ";-.-.-.", "=-...-",
				"+.-.-.", "--....-", "_..--.-", "\".-..-."
			};
			bit [7:0] key;
			foreach (entries[i]) begin
				key = entries[i][0];
				morse[key] = entries[i].substr(1, entries[i].len() - 1);
				coded_chars.push_back(key);
			end
			started = 1'b0;
			errors = 0;
		endfunction

		function void push_sym(symbol_t sym, logic last);
			sym_word_t w;
			w.sym = sym;
			w.last = last;
			pending.push_back(w);
		endfunction

		// expected symbol run for one accepted character
		function void note_char(bit [7:0] ch, bit fresh);
			string code;
			chars_seen++;
			if (started && !fresh) begin
				push_sym(SYM_GAP, 1'b0);
				gaps_seen++;
			end
			started = 1'b1;
			if (ch == CHAR_SPACE) begin
				push_sym(SYM_SLASH, 1'b1);
				spaces_seen++;
			end else if (!morse.exists(ch)) begin
				push_sym(SYM_UNKNOWN, 1'b1);
				uncoded_seen++;
			end else begin
				code = morse[ch];
				for (int i = 0; i < code.len(); i++)
					push_sym(code[i] == "-" ? SYM_DASH : SYM_DOT, i == code.len() - 1);
			end
		endfunction

		function void check_symbol(logic [2:0] sym, logic last);
			sym_word_t w;
			syms_checked++;
			if (pending.size() == 0) begin
				$display("%0t: unexpected symbol word: symbol %0d last %0b", $time, sym, last);
				errors++;
				return;
			end
			w = pending.pop_front();
			if (sym !== w.sym) begin
				$display("%0t: symbol mismatch: expected %0d, actual %0d",
					$time, w.sym, sym);
				errors++;
			end
			if (last !== w.last) begin
				$display("%0t: last mismatch: expected %0b, actual %0b",
					$time, w.last, last);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	int   idle_cycles = 0;
	int   stall_left = 0;
	int   sink_burst = 0;
	int   src_burst = 0;

	morse_scoreboard sb = new();

	mrs_char_if chars();
	mrs_sym_if  syms();

	morse_encoder uut (
		.clk   (clk),
		.arst_n(arst_n),
		.chars (chars),
		.syms  (syms)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// mostly back to back, some short pauses, a few long ones
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 19);
		if (r < 12)
			return 0;
		else if (r < 18)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	task automatic send_char(input bit [7:0] ch, input bit fresh);
		int gap;
		if (src_burst > 0) begin
			gap = 0;
			src_burst--;
		end else begin
			gap = pick_gap();
			if ($urandom_range(0, 24) == 0)
				src_burst = $urandom_range(15, 60);
		end
		if (gap > 0) begin
			chars.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		chars.valid <= 1'b1;
		chars.char_code <= ch;
		chars.new_message <= fresh;
		@(posedge clk);
		while (!chars.ready) @(posedge clk);
	endtask

	// output backpressure
	always @(posedge clk) begin
		if (!arst_n) begin
			syms.ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			syms.ready <= 1'b0;
		end else begin
			syms.ready <= 1'b1;
			if (sink_burst > 0)
				sink_burst--;
			else if ($urandom_range(0, 3) == 0)
				stall_left = pick_gap();
			else if ($urandom_range(0, 31) == 0)
				sink_burst = $urandom_range(20, 80);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (chars.valid && chars.ready)
				sb.note_char(chars.char_code, chars.new_message);
			if (syms.valid && syms.ready)
				sb.check_symbol(syms.symbol, syms.last);
			if ((chars.valid && chars.ready) || (syms.valid && syms.ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		wait (idle_cycles >= IDLE_LIMIT);
		$display("%0t: no word moved for %0d cycles, %0d symbols still due",
			$time, IDLE_LIMIT, sb.pending.size());
		$display("tb: failure");
		$finish;
	end

	initial begin
		// first one with new_message low: still no leading gap after reset
		bit [7:0] dir_chars[] = '{
			"E", "T", " ", "0", "5", ".", ",", "?", "\"", "_", 8'h00, 8'hFF,
			"a", 8'h7F, 8'h80, " ", " ", "Q", "-", "9", "'", "M", "z"
		};
		bit dir_fresh[] = '{
			0, 0, 0, 1, 0, 0, 0, 1, 0, 0, 0, 0,
			0, 1, 0, 1, 0, 0, 1, 0, 0, 0, 1
		};
		int r;
		bit [7:0] ch;
		bit fresh;

		arst_n = 1'b0;
		chars.valid <= 1'b0;
		chars.char_code <= 8'h00;
		chars.new_message <= 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		foreach (dir_chars[i])
			send_char(dir_chars[i], dir_fresh[i]);

		for (int n = 0; n < RANDOM_CHARS; n++) begin
			r = $urandom_range(0, 99);
			if (r < 70)
				ch = sb.coded_chars[$urandom_range(0, sb.coded_chars.size() - 1)];
			else if (r < 80)
				ch = CHAR_SPACE;
			else
				ch = 8'($urandom_range(0, 255));
			fresh = ($urandom_range(0, 6) == 0);
			send_char(ch, fresh);
		end
		chars.valid <= 1'b0;

		// let the last accepted character reach the scoreboard first
		@(posedge clk);
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (12) @(posedge clk);

		$display("covered %0d characters: %0d spaces, %0d bytes without a code, %0d gaps",
			sb.chars_seen, sb.spaces_seen, sb.uncoded_seen, sb.gaps_seen);
		$display("%0d symbol words checked under random input gaps and output stalls",
			sb.syms_checked);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
